// ----- src/gtc_pkg.sv -----
// Shared types, codes and helpers for the giant tour cost and overload evaluator.
`timescale 1ns / 1ps
`default_nettype none

package gtc_pkg;

   // accumulator width: Q32.16
   localparam int ACC_W = 48;

   // defaults for the top level parameters
   localparam int DEF_MAX_LOCATIONS = 128;
   localparam int DEF_VALUE_BITS    = 32;

   // configuration port
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_CAPACITY  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUM_CUSTOMERS = 1'b1;

   localparam logic [31:0] MAX_CAPACITY_RESET  = 32'hFFFF_FFFF;
   localparam logic [7:0]  NUM_CUSTOMERS_RESET = 8'd128;

   typedef enum logic [1:0] {
      ACT_DIST   = 2'd0,
      ACT_DEMAND = 2'd1,
      ACT_TOUR   = 2'd2
   } action_type;

   // what a tour item does once its table reads come back
   typedef struct packed {
      logic add_cost;
      logic add_demand;
      logic close_route;
      logic last;
   } tour_ctrl_type;

   // add, stop at all ones
   function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                input logic [ACC_W-1:0] b);
      logic [ACC_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[ACC_W] ? {ACC_W{1'b1}} : sum[ACC_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- src/giant_tour_cost_and_overload.sv -----
// Top level of the giant tour cost and overload evaluator.
// A result passes from stage 1 through stage 2 into the output register once the last tour item is accepted.
// Throughput: one item per cycle, loads and tour nodes alike; input stalls only when a
// result waits at the output and both pipeline stages behind it are occupied.
// The distance and demand memories take one read each per tour node; the read data is registered.
// Reset clears the accumulators and sets the registers; memories are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module giant_tour_cost_and_overload
   import gtc_pkg::*;
#(
   parameter int MAX_LOCATIONS = DEF_MAX_LOCATIONS,
   parameter int VALUE_BITS    = DEF_VALUE_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // configuration
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wr_data,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [1:0]             req_action,
   input  wire logic [6:0]             req_from_location,
   input  wire logic [6:0]             req_to_location,
   input  wire logic [31:0]            req_table_value,
   input  wire logic [7:0]             req_tour_node,
   input  wire logic                   req_last,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [ACC_W-1:0]            rsp_total_cost,
   output logic [ACC_W-1:0]            rsp_total_overload,
   output logic                        rsp_feasible
);

   localparam int LOC_W      = $clog2(MAX_LOCATIONS);
   localparam int DIST_DEPTH = MAX_LOCATIONS * MAX_LOCATIONS;
   localparam int DIST_AW    = $clog2(DIST_DEPTH);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [31:0] max_capacity_ff, max_capacity_in;
   logic [7:0]  num_customers_ff, num_customers_in;

   always_comb begin
      max_capacity_in  = max_capacity_ff;
      num_customers_in = num_customers_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_MAX_CAPACITY:  max_capacity_in  = csr_wr_data;
            CSR_NUM_CUSTOMERS: num_customers_in = csr_wr_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_capacity_ff  <= MAX_CAPACITY_RESET;
         num_customers_ff <= NUM_CUSTOMERS_RESET;
      end else begin
         max_capacity_ff  <= max_capacity_in;
         num_customers_ff <= num_customers_in;
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control
   // Stage 1 holds a tour item while its table reads return; stage 2 holds
   // the capacity excess of a closed route; then the output register.
   // Only items marked last ever wait on the output register.
   // ------------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   tour_ctrl_type s1_ctrl_ff, s1_ctrl_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          s2_last_ff;
   logic [ACC_W-1:0] s2_excess_ff;
   logic [ACC_W-1:0] s2_cost_ff;
   logic          rsp_valid_ff, rsp_valid_in;

   logic out_free, s2_go, s2_leave, s1_leave, accept, accept_tour;
   action_type action;

   assign action    = action_type'(req_action);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s2_go     = !s2_last_ff || out_free;
   assign s2_leave  = s2_valid_ff && s2_go;
   assign s1_leave  = s1_valid_ff && (!s2_valid_ff || s2_go);
   assign req_stall = s1_valid_ff && !s1_leave;
   assign accept    = req_valid && !req_stall;
   assign accept_tour = accept && (action == ACT_TOUR);

   // ------------------------------------------------------------------
   // Stage 0: classify the node, advance previous location, issue reads
   // ------------------------------------------------------------------
   logic [LOC_W-1:0] prev_loc_ff, prev_loc_in;
   logic             first_pending_ff, first_pending_in;
   logic [31:0]      limit_wide, node_wide, loc_wide, from_wide, to_wide;
   logic [31:0]      dist_waddr_wide, dist_raddr_wide;
   logic             separator;
   logic [LOC_W-1:0] loc;
   logic [63:0]      value_wide;
   logic [VALUE_BITS-1:0] wr_value;
   logic             dist_we, demand_we;
   logic [DIST_AW-1:0] dist_waddr, dist_raddr;
   logic [LOC_W-1:0]   demand_waddr;

   always_comb begin
      // effective customer limit is capped by the table size
      limit_wide = ({24'd0, num_customers_ff} < 32'(MAX_LOCATIONS)) ?
                   {24'd0, num_customers_ff} : 32'(MAX_LOCATIONS);
      node_wide  = {24'd0, req_tour_node};
      separator  = node_wide >= limit_wide;
      loc_wide   = separator ? 32'd0 : node_wide;
      loc        = loc_wide[LOC_W-1:0];

      from_wide  = {25'd0, req_from_location};
      to_wide    = {25'd0, req_to_location};
      value_wide = {32'd0, req_table_value};
      wr_value   = value_wide[VALUE_BITS-1:0];

      dist_waddr_wide = from_wide * 32'(MAX_LOCATIONS) + to_wide;
      dist_raddr_wide = {{(32-LOC_W){1'b0}}, prev_loc_ff} * 32'(MAX_LOCATIONS) + loc_wide;
      dist_waddr      = dist_waddr_wide[DIST_AW-1:0];
      dist_raddr      = dist_raddr_wide[DIST_AW-1:0];
      demand_waddr    = from_wide[LOC_W-1:0];

      dist_we   = 1'b0;
      demand_we = 1'b0;
      if (accept) begin
         unique case (action)
            ACT_DIST:   dist_we   = (from_wide < 32'(MAX_LOCATIONS)) &&
                                    (to_wide < 32'(MAX_LOCATIONS));
            ACT_DEMAND: demand_we = from_wide < 32'(MAX_LOCATIONS);
            default: ;
         endcase
      end

      // the first node of a tour only sets the previous location
      s1_ctrl_in.add_cost    = !first_pending_ff && (loc != prev_loc_ff);
      s1_ctrl_in.add_demand  = !first_pending_ff && !separator;
      s1_ctrl_in.close_route = !first_pending_ff && separator;
      s1_ctrl_in.last        = req_last;

      prev_loc_in      = prev_loc_ff;
      first_pending_in = first_pending_ff;
      if (accept_tour) begin
         prev_loc_in      = req_last ? '0 : loc;
         first_pending_in = req_last;
      end

      s1_valid_in = accept_tour ? 1'b1 : (s1_leave ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_loc_ff      <= '0;
         first_pending_ff <= 1'b1;
         s1_valid_ff      <= 1'b0;
      end else begin
         prev_loc_ff      <= prev_loc_in;
         first_pending_ff <= first_pending_in;
         s1_valid_ff      <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_tour) begin
         s1_ctrl_ff <= s1_ctrl_in;
      end
   end

   // ------------------------------------------------------------------
   // Table memories: write on a load item, read on a tour item. Read data
   // updates only when a tour item enters stage 1, so it holds with it.
   // ------------------------------------------------------------------
   logic [VALUE_BITS-1:0] dist_mem [0:DIST_DEPTH-1];
   logic [VALUE_BITS-1:0] demand_mem [0:MAX_LOCATIONS-1];
   logic [VALUE_BITS-1:0] dist_rd_ff, demand_rd_ff;

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= wr_value;
      end
      if (accept_tour) begin
         dist_rd_ff <= dist_mem[dist_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (demand_we) begin
         demand_mem[demand_waddr] <= wr_value;
      end
      if (accept_tour) begin
         demand_rd_ff <= demand_mem[loc];
      end
   end

   // ------------------------------------------------------------------
   // Stage 1: cost and route load accumulate; a closed route yields its excess
   // ------------------------------------------------------------------
   logic [ACC_W-1:0] cost_sum_ff, cost_sum_in;
   logic [ACC_W-1:0] route_load_ff, route_load_in;
   logic [ACC_W-1:0] cost_next, excess;
   logic [ACC_W:0]   load_diff;

   always_comb begin
      cost_next = s1_ctrl_ff.add_cost ?
                  sat_add(cost_sum_ff, ACC_W'(dist_rd_ff)) : cost_sum_ff;
      // borrow of load minus capacity tells whether the route is over
      load_diff = {1'b0, route_load_ff} - {1'b0, ACC_W'(max_capacity_ff)};
      excess    = (s1_ctrl_ff.close_route && !load_diff[ACC_W]) ?
                  load_diff[ACC_W-1:0] : '0;

      cost_sum_in   = cost_sum_ff;
      route_load_in = route_load_ff;
      if (s1_leave) begin
         if (s1_ctrl_ff.last) begin
            cost_sum_in   = '0;
            route_load_in = '0;
         end else begin
            cost_sum_in = cost_next;
            if (s1_ctrl_ff.close_route) begin
               route_load_in = '0;
            end else if (s1_ctrl_ff.add_demand) begin
               route_load_in = sat_add(route_load_ff, ACC_W'(demand_rd_ff));
            end
         end
      end

      s2_valid_in = s1_leave ? 1'b1 : (s2_leave ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_sum_ff   <= '0;
         route_load_ff <= '0;
         s2_valid_ff   <= 1'b0;
      end else begin
         cost_sum_ff   <= cost_sum_in;
         route_load_ff <= route_load_in;
         s2_valid_ff   <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_leave) begin
         s2_last_ff   <= s1_ctrl_ff.last;
         s2_excess_ff <= excess;
         s2_cost_ff   <= cost_next;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: overload accumulates; a last item loads the output register
   // ------------------------------------------------------------------
   logic [ACC_W-1:0] overload_sum_ff, overload_sum_in;
   logic [ACC_W-1:0] overload_next;
   logic             load_out;
   logic [ACC_W-1:0] rsp_cost_ff, rsp_overload_ff;
   logic             rsp_feasible_ff;

   always_comb begin
      overload_next = sat_add(overload_sum_ff, s2_excess_ff);
      load_out      = s2_leave && s2_last_ff;

      overload_sum_in = overload_sum_ff;
      if (s2_leave) begin
         overload_sum_in = s2_last_ff ? '0 : overload_next;
      end

      rsp_valid_in = load_out ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overload_sum_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         overload_sum_ff <= overload_sum_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_cost_ff     <= s2_cost_ff;
         rsp_overload_ff <= overload_next;
         // saturating sum of non-negative terms is zero only if both are
         rsp_feasible_ff <= (overload_sum_ff == '0) && (s2_excess_ff == '0);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_total_cost     = rsp_cost_ff;
   assign rsp_total_overload = rsp_overload_ff;
   assign rsp_feasible       = rsp_feasible_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // input stalls only behind a full pipeline with a result held at the output
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s2_valid_ff && s2_last_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled while the pipeline has room");

   // feasible result carries no overload
   a_feasible: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_feasible) |-> (rsp_total_overload == '0))
      else $error("feasible result with nonzero overload");

   // a last tour node re-arms the start of the next tour
   a_rearm: assert property (@(posedge clock) disable iff (reset)
      (accept_tour && req_last) |=> (first_pending_ff && (prev_loc_ff == '0)))
      else $error("tour state not cleared after last node");

   // a delivered last item leaves the overload sum cleared
   a_ovl_clear: assert property (@(posedge clock) disable iff (reset)
      load_out |=> (overload_sum_ff == '0) && rsp_valid_ff)
      else $error("overload sum not cleared after result");

   // a result is produced only from a last item in stage 2
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_valid_ff)) |-> $past(s2_valid_ff && s2_last_ff))
      else $error("result without a last item");

endmodule

`default_nettype wire
